// ===== design/assert_macros.svh =====
// Assertion macros shared by the path hash design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pcxh_pkg.sv =====
// Package with types and constants of the path component XOR hash.
package pcxh_pkg;

  // Width of the hash, the seed and the digest.
  localparam int unsigned HashW = 64;

  // Default number of bytes packed into one full word.
  localparam int unsigned WordBytesDef = 8;

  // Separator and terminator bytes in path mode.
  localparam logic [7:0] SlashByte = 8'h2F;
  localparam logic [7:0] NulByte   = 8'h00;

  // Multiplying by nine is one shift by this amount plus an add.
  localparam int unsigned MulShift = 3;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  // One input beat as held in the input register.
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic [HashW-1:0]  seed;
    logic              split_mode;
  } item_t;

endpackage

// ===== design/pcxh_core.sv =====
// Hash state and its update logic for one registered input item.
`include "assert_macros.svh"

module pcxh_core
  import pcxh_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WordBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  item_t            item_i,
  output logic [HashW-1:0] result_o
);

  localparam int unsigned CntW = $clog2(WORD_BYTES);

  // Hash state.
  logic [HashW-1:0]                  digest_q, digest_d;
  logic [HashW-1:0]                  hash_q, hash_d;
  logic [WORD_BYTES-1:0][7:0]        pend_q, pend_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [HashW-1:0]                  rest_q, rest_d;
  logic                              path_mode_q, path_mode_d;
  logic                              stopped_q, stopped_d;

  // Datapath terms.
  logic [7:0]                        b;
  logic                              is_data;
  logic                              live_path;
  logic                              take_byte;
  logic                              close_slash;
  logic                              set_stop;
  logic [HashW-1:0]                  close_sum;
  logic [HashW-1:0]                  closed;
  logic [WORD_BYTES-1:0][7:0]        pend_ins;
  logic                              word_full;
  logic [HashW-1:0]                  word_sum;
  logic [HashW-1:0]                  word_hash;
  logic [HashW-1:0]                  rest_new;

  // Byte classification against the current mode.
  assign b           = item_i.data_byte;
  assign is_data     = (item_i.kind == KIND_DATA);
  assign live_path   = is_data && path_mode_q && !stopped_q;
  assign take_byte   = (is_data && !path_mode_q)
                     || (live_path && (b != NulByte) && (b != SlashByte));
  assign close_slash = live_path && (b == SlashByte);
  assign set_stop    = live_path && (b == NulByte);

  // Closing a component folds in the big-endian tail kept in rest_q.
  assign close_sum = hash_q + rest_q;
  assign closed    = (cnt_q != '0) ? (close_sum + (close_sum << MulShift)) : hash_q;
  assign result_o  = digest_q ^ closed;

  // Little-endian packing of the current word and its hash when it fills.
  always_comb begin
    pend_ins        = pend_q;
    pend_ins[cnt_q] = b;
  end
  assign word_full = (cnt_q == CntW'(WORD_BYTES - 1));
  assign word_sum  = hash_q + HashW'(pend_ins);
  assign word_hash = word_sum + (word_sum << MulShift);

  // Tail value with sign-extended bytes, kept up to date on every byte.
  assign rest_new = (rest_q << 8) + {{(HashW-8){b[7]}}, b};

  // Next state for each item kind.
  always_comb begin
    digest_d    = digest_q;
    hash_d      = hash_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    rest_d      = rest_q;
    path_mode_d = path_mode_q;
    stopped_d   = stopped_q;
    unique case (item_i.kind)
      KIND_START: begin
        digest_d    = item_i.seed;
        path_mode_d = item_i.split_mode;
        stopped_d   = 1'b0;
        hash_d      = '0;
        pend_d      = '0;
        cnt_d       = '0;
        rest_d      = '0;
      end
      KIND_DATA: begin
        if (take_byte) begin
          if (word_full) begin
            hash_d = word_hash;
            pend_d = '0;
            cnt_d  = '0;
            rest_d = '0;
          end else begin
            pend_d = pend_ins;
            cnt_d  = cnt_q + CntW'(1);
            rest_d = rest_new;
          end
        end
        if (close_slash) begin
          digest_d = digest_q ^ closed;
          hash_d   = '0;
          pend_d   = '0;
          cnt_d    = '0;
          rest_d   = '0;
        end
        if (set_stop) begin
          stopped_d = 1'b1;
        end
      end
      KIND_END: begin
        digest_d  = '0;
        hash_d    = '0;
        pend_d    = '0;
        cnt_d     = '0;
        rest_d    = '0;
        stopped_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // State registers, updated only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_q    <= '0;
      hash_q      <= '0;
      pend_q      <= '0;
      cnt_q       <= '0;
      rest_q      <= '0;
      path_mode_q <= 1'b0;
      stopped_q   <= 1'b0;
    end else if (fire_i) begin
      digest_q    <= digest_d;
      hash_q      <= hash_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      rest_q      <= rest_d;
      path_mode_q <= path_mode_d;
      stopped_q   <= stopped_d;
    end
  end

  // A NUL stop can only exist in path mode.
  `ASSERT_IMPLIES(a_stop_needs_path, clk_i, rst_ni, stopped_q, path_mode_q, "stop outside path mode")

  // An end item leaves an empty component and a cleared digest.
  `ASSERT_NEXT(a_end_clears, clk_i, rst_ni, fire_i && (item_i.kind == KIND_END), (cnt_q == '0) && (hash_q == '0) && (digest_q == '0), "end item did not clear state")

  // A slash in live path mode always leaves an empty component.
  `ASSERT_NEXT(a_slash_clears, clk_i, rst_ni, fire_i && close_slash, (cnt_q == '0) && (rest_q == '0), "slash did not close component")

endmodule

// ===== design/path_component_xor_hash_top.sv =====
// Path component XOR hash: stream a path or name a byte per beat and emit a 64-bit digest.
//
// Input channel (in_valid_i / in_stall_o): one beat per cycle while in_stall_o is low.
// kind_i selects a start beat (seed_i and split_mode_i load the digest and mode), a data
// beat (data_byte_i) or an end beat. Kind three is dropped with no result.
// Output channel (out_valid_o / out_stall_i): one digest_o beat for each end beat.
// A beat moves on a rising edge where valid is high and stall is low.
// An accepted beat sits in the input register, and the core works on it there. The edge
// that updates the hash state also loads an end beat's digest into the result register and
// raises out_valid_o. Throughput: one beat per cycle while in_stall_o is low; a full word or
// a closed component updates the hash with one shift-and-add multiply by nine between the
// input register and the state and result registers.
// When the receiver stalls, the held digest stays put; data and start beats keep flowing,
// and an end beat waits in the input register, which then raises in_stall_o.
// Reset clears the hash state to seed zero in name mode and empties both registers.
`include "assert_macros.svh"

module path_component_xor_hash_top
  import pcxh_pkg::*;
#(
  parameter int unsigned WORD_BYTES = WordBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [7:0]       data_byte_i,
  input  logic [HashW-1:0] seed_i,
  input  logic             split_mode_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [HashW-1:0] digest_o
);

  logic             s1_valid_q, s1_valid_d;
  item_t            s1_item_q;
  logic             in_accept;
  logic             fire;
  logic             fire_end;
  logic             out_valid_q, out_valid_d;
  logic [HashW-1:0] digest_q;
  logic [HashW-1:0] core_result;

  // An end beat needs a free result register; other kinds always proceed.
  assign fire       = s1_valid_q
                    && ((s1_item_q.kind != KIND_END) || !out_valid_q || !out_stall_i);
  assign fire_end   = fire && (s1_item_q.kind == KIND_END);
  assign in_stall_o = s1_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register occupancy.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  // Result register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire_end) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.kind       <= kind_e'(kind_i);
      s1_item_q.data_byte  <= data_byte_i;
      s1_item_q.seed       <= seed_i;
      s1_item_q.split_mode <= split_mode_i;
    end
    if (fire_end) begin
      digest_q <= core_result;
    end
  end

  pcxh_core #(
    .WORD_BYTES (WORD_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .result_o (core_result)
  );

  assign out_valid_o = out_valid_q;
  assign digest_o    = digest_q;

  // A processed end beat always leaves a digest waiting.
  `ASSERT_NEXT(a_end_gives_result, clk_i, rst_ni, fire_end, out_valid_q, "end beat lost")

  // A new digest appears only after an end beat was processed.
  `ASSERT_IMPLIES(a_result_from_end, clk_i, rst_ni, $rose(out_valid_q), $past(fire_end), "digest without end beat")

  // A full, stalled result register holds back a pending end beat.
  `ASSERT_IMPLIES(a_end_backpressure, clk_i, rst_ni, s1_valid_q && (s1_item_q.kind == KIND_END) && out_valid_q && out_stall_i, in_stall_o && !fire, "end beat overran result")

endmodule
